### hdl/cht_pkg.sv
// Package with the types and constants shared by the cache hit/miss tracker.
`default_nettype none
package cht_pkg;

  localparam int LINE_BYTES = 64;
  localparam int ADDRESS_BITS = 32;
  localparam int MAX_LINES = 64;

  localparam int OFFSET_W = $clog2(LINE_BYTES);
  localparam int ENTRY_W = $clog2(MAX_LINES);
  localparam int TAG_W = ADDRESS_BITS - OFFSET_W;
  localparam int COUNT_W = 32;
  localparam int SIZE_W = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = SIZE_W;

  localparam logic [SIZE_W-1:0] SIZE_LOG2_MIN = SIZE_W'(7);
  localparam logic [SIZE_W-1:0] SIZE_LOG2_MAX = SIZE_W'(12);
  localparam logic [SIZE_W-1:0] SIZE_LOG2_RESET = SIZE_W'(12);

  localparam logic [CFG_INDEX_W-1:0] CFG_CACHE_SIZE_LOG2 = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_FULLY_ASSOCIATIVE = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] CFG_SPLIT_CACHE = CFG_INDEX_W'(2);

  typedef struct packed {
    logic [ADDRESS_BITS-1:0] address;
    logic                    access_kind;
  } request_t;

  typedef struct packed {
    logic               hit;
    logic [COUNT_W-1:0] access_count;
    logic [COUNT_W-1:0] hit_count;
  } result_t;

  typedef struct packed {
    logic [SIZE_W-1:0] cache_size_log2;
    logic              fully_associative;
    logic              split_cache;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic hit;
  } lookup_t;

endpackage
`default_nettype wire

### hdl/cht_tag_store.sv
// Tag store with valid bits and FIFO pointers; looks up and updates one access per cycle.
`default_nettype none
module cht_tag_store (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cht_pkg::cfg_t     cfg,
  input  wire logic              req_valid,
  input  wire cht_pkg::request_t req,
  output cht_pkg::lookup_t       lookup
);

  localparam int EW = cht_pkg::ENTRY_W;
  localparam int TW = cht_pkg::TAG_W;
  localparam int LW = $clog2(EW + 1);
  localparam logic [cht_pkg::SIZE_W-1:0] OFFSET_LOG2 = cht_pkg::SIZE_W'(cht_pkg::OFFSET_W);
  localparam logic [cht_pkg::SIZE_W-1:0] ENTRY_LOG2 = cht_pkg::SIZE_W'(EW);

  logic [TW-1:0] line_tags [cht_pkg::MAX_LINES];
  logic [cht_pkg::MAX_LINES-1:0] line_valid;
  logic [EW-1:0] fifo_pointers [2];

  logic [cht_pkg::SIZE_W-1:0] size_clamped;
  logic [cht_pkg::SIZE_W-1:0] lines_log2;
  logic [LW-1:0] half_log2;
  logic [EW:0] span;
  logic [EW-1:0] span_mask;
  logic [EW:0] base;
  logic [EW:0] limit;
  logic sel;
  logic [TW-1:0] line_no;
  logic [TW-1:0] dm_tag;
  logic [EW-1:0] dm_entry;
  logic [cht_pkg::MAX_LINES-1:0] in_range;
  logic [cht_pkg::MAX_LINES-1:0] match;
  logic [cht_pkg::MAX_LINES-1:0] empty;
  logic [EW-1:0] fill_entry;
  logic [EW-1:0] fifo_slot;
  logic hit;
  logic wr_en;
  logic [EW-1:0] wr_entry;
  logic [TW-1:0] wr_tag;
  logic ptr_adv;

  always_comb begin
    if (cfg.cache_size_log2 < cht_pkg::SIZE_LOG2_MIN) begin
      size_clamped = cht_pkg::SIZE_LOG2_MIN;
    end else if (cfg.cache_size_log2 > cht_pkg::SIZE_LOG2_MAX) begin
      size_clamped = cht_pkg::SIZE_LOG2_MAX;
    end else begin
      size_clamped = cfg.cache_size_log2;
    end
    lines_log2 = size_clamped - OFFSET_LOG2;
    if (lines_log2 > ENTRY_LOG2) begin
      lines_log2 = ENTRY_LOG2;
    end
    if (lines_log2 < cht_pkg::SIZE_W'(1)) begin
      lines_log2 = cht_pkg::SIZE_W'(1);
    end
    half_log2 = cfg.split_cache ? LW'(lines_log2 - cht_pkg::SIZE_W'(1)) : LW'(lines_log2);
    span = (EW+1)'(1) << half_log2;
    span_mask = EW'(span - (EW+1)'(1));
    sel = cfg.split_cache & req.access_kind;
    base = sel ? span : '0;
    limit = base + span;
    line_no = req.address[cht_pkg::ADDRESS_BITS-1:cht_pkg::OFFSET_W];
    dm_tag = line_no >> half_log2;
    dm_entry = EW'(base) + (EW'(line_no) & span_mask);
  end

  always_comb begin
    for (int i = 0; i < cht_pkg::MAX_LINES; i++) begin
      in_range[i] = ((EW+1)'(i) >= base) && ((EW+1)'(i) < limit);
      match[i] = in_range[i] && line_valid[i] && (line_tags[i] == line_no);
      empty[i] = in_range[i] && !line_valid[i];
    end
  end

  always_comb begin
    fill_entry = '0;
    for (int i = cht_pkg::MAX_LINES - 1; i >= 0; i--) begin
      if (empty[i]) begin
        fill_entry = EW'(i);
      end
    end
  end

  always_comb begin
    fifo_slot = fifo_pointers[sel] & span_mask;
    ptr_adv = 1'b0;
    if (!cfg.fully_associative) begin
      hit = line_valid[dm_entry] && (line_tags[dm_entry] == dm_tag);
      wr_en = req_valid && !hit;
      wr_entry = dm_entry;
      wr_tag = dm_tag;
    end else begin
      hit = |match;
      wr_en = req_valid && !hit;
      wr_tag = line_no;
      if (|empty) begin
        wr_entry = fill_entry;
      end else begin
        wr_entry = EW'(base) + fifo_slot;
        ptr_adv = wr_en;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_valid <= '0;
      fifo_pointers[0] <= '0;
      fifo_pointers[1] <= '0;
    end else begin
      if (wr_en) begin
        line_valid[wr_entry] <= 1'b1;
      end
      if (ptr_adv) begin
        fifo_pointers[sel] <= (fifo_slot + EW'(1)) & span_mask;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_tags[wr_entry] <= wr_tag;
    end
  end

  assign lookup.valid = req_valid;
  assign lookup.hit = hit;

endmodule
`default_nettype wire

### hdl/cht_stats.sv
// Saturating access and hit counters and the registered result.
`default_nettype none
module cht_stats (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cht_pkg::lookup_t lookup,
  output logic                  done,
  output cht_pkg::result_t      rsp
);

  logic [cht_pkg::COUNT_W-1:0] access_counter;
  logic [cht_pkg::COUNT_W-1:0] hit_counter;
  logic hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      access_counter <= '0;
      hit_counter <= '0;
      done <= 1'b0;
      hit <= 1'b0;
    end else begin
      done <= lookup.valid;
      if (lookup.valid) begin
        hit <= lookup.hit;
        if (!(&access_counter)) begin
          access_counter <= access_counter + cht_pkg::COUNT_W'(1);
        end
        if (lookup.hit && !(&hit_counter)) begin
          hit_counter <= hit_counter + cht_pkg::COUNT_W'(1);
        end
      end
    end
  end

  assign rsp.hit = hit;
  assign rsp.access_count = access_counter;
  assign rsp.hit_count = hit_counter;

endmodule
`default_nettype wire

### hdl/cache_hit_miss_tracker_core.sv
// Top level of the cache hit/miss tracker: configuration registers and input register.
//
// The block takes one access in every clock cycle and never raises busy. An access
// taken at a clock edge is held in the input register, where the tag lookup and
// the tag, valid and FIFO updates run; the stats registers then capture the result,
// which is shown on rsp with done high. The receiver cannot stall: each transfer
// lasts exactly one cycle. Valid bits live in flip-flops and clear at reset, so no
// clearing pass is needed.
`default_nettype none
module cache_hit_miss_tracker_core (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire cht_pkg::request_t                  req,
  output logic                                    done,
  output cht_pkg::result_t                        rsp,
  input  wire logic                               cfg_we,
  input  wire logic [cht_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [cht_pkg::CFG_DATA_W-1:0]     cfg_data
);

  cht_pkg::cfg_t cfg;
  cht_pkg::request_t req_reg;
  logic req_valid;
  cht_pkg::lookup_t lookup;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cache_size_log2 <= cht_pkg::SIZE_LOG2_RESET;
      cfg.fully_associative <= 1'b0;
      cfg.split_cache <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        cht_pkg::CFG_CACHE_SIZE_LOG2: cfg.cache_size_log2 <= cfg_data;
        cht_pkg::CFG_FULLY_ASSOCIATIVE: cfg.fully_associative <= cfg_data[0];
        cht_pkg::CFG_SPLIT_CACHE: cfg.split_cache <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_reg <= req;
    end
  end

  cht_tag_store u_tag_store (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req_valid (req_valid),
    .req       (req_reg),
    .lookup    (lookup)
  );

  cht_stats u_stats (
    .clk    (clk),
    .rst    (rst),
    .lookup (lookup),
    .done   (done),
    .rsp    (rsp)
  );

endmodule
`default_nettype wire

### verif/cache_hit_miss_tracker_core_tb.sv
// Self-checking testbench for the cache hit/miss tracker with a predicting tag store.
`default_nettype none
module cache_hit_miss_tracker_core_tb;
  import cht_pkg::*;

  localparam int SETTLE_CYCLES = 6;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 100;

  class tracker_model;
    logic [TAG_W-1:0] line_tag [MAX_LINES];
    bit line_valid [MAX_LINES];
    logic [ENTRY_W-1:0] fifo_ptr [2];
    logic [COUNT_W-1:0] access_total;
    logic [COUNT_W-1:0] hit_total;
    logic [SIZE_W-1:0] size_log2;
    bit assoc;
    bit split;
    result_t expected_results[$];
    int mismatches;

    function new();
      for (int i = 0; i < MAX_LINES; i++) begin
        line_tag[i] = '0;
        line_valid[i] = 1'b0;
      end
      fifo_ptr[0] = '0;
      fifo_ptr[1] = '0;
      access_total = '0;
      hit_total = '0;
      size_log2 = SIZE_LOG2_RESET;
      assoc = 1'b0;
      split = 1'b0;
      mismatches = 0;
    endfunction

    function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_CACHE_SIZE_LOG2: size_log2 = data;
        CFG_FULLY_ASSOCIATIVE: assoc = data[0];
        CFG_SPLIT_CACHE: split = data[0];
        default: ;
      endcase
    endfunction

    function result_t lookup_access(request_t a);
      result_t r;
      logic [SIZE_W-1:0] lg;
      logic [TAG_W-1:0] line_no;
      logic [TAG_W-1:0] tag;
      int unsigned lines;
      int unsigned base;
      int unsigned sel;
      int unsigned e;
      int unsigned p;
      bit hit;
      bit filled;
      lg = size_log2;
      if (lg < SIZE_LOG2_MIN) lg = SIZE_LOG2_MIN;
      if (lg > SIZE_LOG2_MAX) lg = SIZE_LOG2_MAX;
      lines = (32'd1 << lg) / LINE_BYTES;
      line_no = a.address[ADDRESS_BITS-1:OFFSET_W];
      base = 0;
      sel = 0;
      hit = 1'b0;
      filled = 1'b0;
      if (split) begin
        lines = lines / 2;
        sel = 32'(a.access_kind);
        base = a.access_kind ? lines : 0;
      end
      if (!assoc) begin
        e = base + (line_no % lines);
        tag = TAG_W'(line_no / lines);
        if (line_valid[e] && line_tag[e] == tag) begin
          hit = 1'b1;
        end else begin
          line_valid[e] = 1'b1;
          line_tag[e] = tag;
        end
      end else begin
        for (int i = 0; i < lines; i++) begin
          if (!hit && line_valid[base + i] && line_tag[base + i] == line_no) hit = 1'b1;
        end
        if (!hit) begin
          for (int i = 0; i < lines; i++) begin
            if (!filled && !line_valid[base + i]) begin
              line_valid[base + i] = 1'b1;
              line_tag[base + i] = line_no;
              filled = 1'b1;
            end
          end
          if (!filled) begin
            p = fifo_ptr[sel] % lines;
            line_tag[base + p] = line_no;
            fifo_ptr[sel] = ENTRY_W'((p + 1) % lines);
          end
        end
      end
      if (access_total != '1) access_total = access_total + COUNT_W'(1);
      if (hit && hit_total != '1) hit_total = hit_total + COUNT_W'(1);
      r.hit = hit;
      r.access_count = access_total;
      r.hit_count = hit_total;
      return r;
    endfunction

    function void note_access(request_t a);
      expected_results.push_back(lookup_access(a));
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        report_mismatch("result arrived with no access outstanding");
        return;
      end
      want = expected_results.pop_front();
      if (got.hit !== want.hit)
        report_mismatch($sformatf("hit %0b, expected %0b", got.hit, want.hit));
      if (got.access_count !== want.access_count)
        report_mismatch($sformatf("access_count %0d, expected %0d",
                                  got.access_count, want.access_count));
      if (got.hit_count !== want.hit_count)
        report_mismatch($sformatf("hit_count %0d, expected %0d",
                                  got.hit_count, want.hit_count));
    endtask

    function int outstanding();
      return expected_results.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  request_t req;
  logic done;
  result_t rsp;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tracker_model board;
  logic [TAG_W-1:0] line_pool[$];

  cache_hit_miss_tracker_core dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .done(done),
    .rsp(rsp),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (done) board.check_result(rsp);
      if (cfg_we) board.write_register(cfg_index, cfg_data);
      if (start && !busy) board.note_access(req);
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("cache_hit_miss_tracker_core test failed");
    $finish;
  end

  task send_access(logic [ADDRESS_BITS-1:0] addr, logic kind);
    start = 1'b1;
    req.address = addr;
    req.access_kind = kind;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task idle_cycles(int n);
    if (n > 0) begin
      start = 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task wait_drained();
    start = 1'b0;
    while (board.outstanding() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
  endtask

  task configure(logic [SIZE_W-1:0] size, logic assoc, logic split);
    wait_drained();
    write_register(CFG_CACHE_SIZE_LOG2, size);
    write_register(CFG_FULLY_ASSOCIATIVE, {(CFG_DATA_W-1)'($urandom), assoc});
    write_register(CFG_SPLIT_CACHE, {(CFG_DATA_W-1)'($urandom), split});
    cfg_we = 1'b0;
    @(negedge clk);
  endtask

  task run_directed();
    // Default setup: an invalid line holding tag zero must still miss, and kind is ignored.
    send_access(32'h0000_0000, 1'b0);
    send_access(32'h0000_003F, 1'b1);
    send_access(32'hFFFF_FFFF, 1'b1);
    send_access(32'hFFFF_FFC0, 1'b0);
    send_access(32'h0000_1000, 1'b0);
    send_access(32'h0000_0000, 1'b0);
    // Size above the range acts as the largest size; split halves.
    configure(SIZE_W'(15), 1'b0, 1'b1);
    send_access(32'h0000_0000, 1'b1);
    send_access(32'h0000_0000, 1'b0);
    send_access(32'h0000_0800, 1'b0);
    // Size below the range acts as the smallest; fully associative with FIFO wrap.
    configure(SIZE_W'(0), 1'b1, 1'b0);
    send_access(32'h0000_0100, 1'b0);
    send_access(32'h0000_0200, 1'b1);
    send_access(32'h0000_0300, 1'b0);
    send_access(32'h0000_0100, 1'b0);
    send_access(32'h0000_0200, 1'b0);
    send_access(32'h0000_0300, 1'b1);
    send_access(32'h0000_0400, 1'b0);
    configure(SIZE_W'(7), 1'b1, 1'b1);
    send_access(32'h0000_0100, 1'b0);
    send_access(32'h0000_0100, 1'b1);
    send_access(32'h0000_0200, 1'b0);
    send_access(32'h0000_0100, 1'b0);
    configure(SIZE_W'(12), 1'b1, 1'b1);
    send_access(32'hFFFF_FFFF, 1'b1);
    send_access(32'h0000_0000, 1'b0);
    send_access(32'hFFFF_FFFF, 1'b1);
  endtask

  task run_phase(int phase);
    int pool_size;
    int burst_left;
    logic [ADDRESS_BITS-1:0] addr;
    bit no_gaps;
    line_pool.delete();
    pool_size = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 8) : $urandom_range(8, 96);
    for (int i = 0; i < pool_size; i++) line_pool.push_back(TAG_W'($urandom));
    no_gaps = (phase % 4 == 1);
    burst_left = $urandom_range(1, 24);
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if ($urandom_range(0, 4) != 0)
        addr = {line_pool[$urandom_range(0, pool_size - 1)], OFFSET_W'($urandom)};
      else
        addr = $urandom;
      send_access(addr, 1'($urandom_range(0, 1)));
      if (phase == 3 && i == PHASE_ITEMS / 2) wait_drained();
      burst_left--;
      if (burst_left == 0) begin
        if (!no_gaps)
          idle_cycles(($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 4));
        burst_left = $urandom_range(1, 24);
      end
    end
  endtask

  initial begin
    board = new();
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    run_directed();
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: configure(SIZE_W'(7), 1'b0, 1'b0);
        1: configure(SIZE_W'(12), 1'b1, 1'b1);
        2: configure(SIZE_W'(7), 1'b1, 1'b1);
        3: configure(SIZE_W'(12), 1'b0, 1'b1);
        4: configure(SIZE_W'(0), 1'b1, 1'b0);
        5: configure(SIZE_W'(15), 1'b0, 1'b0);
        default: configure(SIZE_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)));
      endcase
      run_phase(ph);
    end
    wait_drained();
    if (board.mismatches == 0) begin
      $display("cache_hit_miss_tracker_core test passed");
    end else begin
      $display("cache_hit_miss_tracker_core test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
